### rtl/fqr_pkg.sv
// ----------------------------------------------------------------------------
// fqr_pkg: shared types and constants of the tag queue
// Sizes, request and status codes, and the controller command struct.
// ----------------------------------------------------------------------------
package fqr_pkg;

	localparam int DEPTH     = 16;
	localparam int TAG_WIDTH = 32;
	localparam int FILL_W    = $clog2(DEPTH + 1);
	localparam int IDX_W     = $clog2(DEPTH);
	localparam int IO_TAG_W  = 32;

	localparam logic [1:0] KIND_ENQ = 2'd0;
	localparam logic [1:0] KIND_DEQ = 2'd1;
	localparam logic [1:0] KIND_REM = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EMPTY     = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	typedef enum logic {
		OUT_IDLE,
		OUT_HOLD
	} out_state_t;

	typedef struct packed {
		logic exec;
	} ctl_cmd_t;

endpackage

### rtl/fqr_req_if.sv
// ----------------------------------------------------------------------------
// fqr_req_if: request channel
// Valid/ready channel carrying one queue request per item.
// ----------------------------------------------------------------------------
interface fqr_req_if import fqr_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [1:0]          kind;
	logic [IO_TAG_W-1:0] tag;

	modport source (output valid, output kind, output tag, input ready);
	modport sink   (input valid, input kind, input tag, output ready);
endinterface

### rtl/fqr_rsp_if.sv
// ----------------------------------------------------------------------------
// fqr_rsp_if: response channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface fqr_rsp_if import fqr_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [1:0]          status;
	logic [IO_TAG_W-1:0] out_tag;
	logic                now_empty;

	modport source (output valid, output status, output out_tag, output now_empty,
		input ready);
	modport sink   (input valid, input status, input out_tag, input now_empty,
		output ready);
endinterface

### rtl/fifo_queue_with_remove_core.sv
// ----------------------------------------------------------------------------
// fifo_queue_with_remove_core: ordered tag queue with remove by value
// Bounded first-in first-out queue of tags supporting enqueue, dequeue and
// removal of the first entry equal to a given tag.
// ----------------------------------------------------------------------------
//
//   channel | dir | handshake   | payload
//   --------+-----+-------------+-----------------------------
//   req     | in  | valid/ready | kind[1:0], tag[31:0]
//   rsp     | out | valid/ready | status[1:0], out_tag[31:0], now_empty
//
// Each request executes in the cycle it is accepted and its result sits in
// the response register from the next cycle, so one item per cycle is
// sustained while the response side keeps taking results. A new request is
// accepted whenever that register is empty or is being emptied in the same
// cycle, so a response stall stalls the request side and no item is lost.
// Reset empties the queue at once; slots are never read before written.
//
module fifo_queue_with_remove_core import fqr_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	fqr_req_if.sink   req,
	fqr_rsp_if.source rsp
);

	ctl_cmd_t cmd;

	// The controller tracks whether the response register holds an item and
	// decides when a request executes.
	fqr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	// The datapath holds the slots and the fill count, matches the tag against
	// all occupied slots in parallel and shifts entries down to close a gap.
	fqr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.kind      (req.kind),
		.tag       (req.tag),
		.status    (rsp.status),
		.out_tag   (rsp.out_tag),
		.now_empty (rsp.now_empty)
	);

endmodule

### rtl/fqr_ctrl.sv
// ----------------------------------------------------------------------------
// fqr_ctrl: queue controller
// Tracks the output register and issues one execute command per item.
// ----------------------------------------------------------------------------
module fqr_ctrl import fqr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output ctl_cmd_t cmd
);

	out_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= OUT_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		rsp_valid = 1'b0;
		req_ready = 1'b0;
		cmd.exec  = 1'b0;
		case (state_q)
			OUT_IDLE: begin
				req_ready = 1'b1;
			end
			OUT_HOLD: begin
				rsp_valid = 1'b1;
				req_ready = rsp_ready;
			end
			default: begin
				req_ready = 1'b1;
			end
		endcase
		cmd.exec = req_valid && req_ready;
		if (cmd.exec) begin
			state_d = OUT_HOLD;
		end else if (rsp_valid && rsp_ready) begin
			state_d = OUT_IDLE;
		end
	end

endmodule

### rtl/fqr_dp.sv
// ----------------------------------------------------------------------------
// fqr_dp: queue datapath
// Slot registers, parallel tag match, gap-closing shift and result register.
// ----------------------------------------------------------------------------
module fqr_dp import fqr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  ctl_cmd_t            cmd,
	input  logic [1:0]          kind,
	input  logic [IO_TAG_W-1:0] tag,
	output logic [1:0]          status,
	output logic [IO_TAG_W-1:0] out_tag,
	output logic                now_empty
);

	logic [TAG_WIDTH-1:0] slots_q [DEPTH];
	logic [FILL_W-1:0]    fill_q;
	logic [FILL_W-1:0]    fill_d;

	logic [63:0]          tag_ext;
	logic [TAG_WIDTH-1:0] tag_k;
	logic [63:0]          head_ext;
	logic [DEPTH-1:0]     match;
	logic [DEPTH-1:0]     first;
	logic [DEPTH-1:0]     shift_mask;
	logic                 do_shift;
	logic                 do_write;
	logic [IDX_W-1:0]     wr_idx;
	logic [1:0]           status_d;
	logic [IO_TAG_W-1:0]  taken_d;

	logic [1:0]           status_q;
	logic [IO_TAG_W-1:0]  out_tag_q;
	logic                 now_empty_q;

	assign tag_ext  = 64'(tag);
	assign tag_k    = tag_ext[TAG_WIDTH-1:0];
	assign head_ext = 64'(slots_q[0]);
	assign wr_idx   = fill_q[IDX_W-1:0];

	// Compare the tag against every occupied slot at once.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			match[i] = (FILL_W'(i) < fill_q) && (slots_q[i] == tag_k);
		end
	end

	// Lowest matching slot, and the slots at or above it that move down.
	assign first = match & (~match + DEPTH'(1));

	always_comb begin
		fill_d     = fill_q;
		do_shift   = 1'b0;
		do_write   = 1'b0;
		shift_mask = ~(first - DEPTH'(1));
		status_d   = ST_OK;
		taken_d    = '0;
		case (kind)
			KIND_ENQ: begin
				if (fill_q == FILL_W'(DEPTH)) begin
					status_d = ST_FULL;
				end else begin
					do_write = 1'b1;
					fill_d   = fill_q + FILL_W'(1);
				end
			end
			KIND_DEQ: begin
				if (fill_q == '0) begin
					status_d = ST_EMPTY;
				end else begin
					taken_d    = head_ext[IO_TAG_W-1:0];
					shift_mask = '1;
					do_shift   = 1'b1;
					fill_d     = fill_q - FILL_W'(1);
				end
			end
			KIND_REM: begin
				if (match == '0) begin
					status_d = ST_NOT_FOUND;
				end else begin
					do_shift = 1'b1;
					fill_d   = fill_q - FILL_W'(1);
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.exec) begin
			fill_q <= fill_d;
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_slot
		always_ff @(posedge clk) begin
			if (cmd.exec) begin
				if (do_shift && shift_mask[g]) begin
					if (g < DEPTH - 1) begin
						slots_q[g] <= slots_q[(g + 1) % DEPTH];
					end
				end else if (do_write && (wr_idx == IDX_W'(g))) begin
					slots_q[g] <= tag_k;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q    <= status_d;
			out_tag_q   <= taken_d;
			now_empty_q <= (fill_d == '0);
		end
	end

	assign status    = status_q;
	assign out_tag   = out_tag_q;
	assign now_empty = now_empty_q;

endmodule
